>>> rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table: item formats, function
// and status codes, reset capacity, stored entry, controller/datapath link.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_DUP   = 3'd2;
   localparam logic [2:0] ST_MISS  = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   localparam logic [8:0] CAP_RESET = 9'd256;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [63:0] search_key;
      logic [31:0]        new_page;
      logic [15:0]        new_slot;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [63:0] found_key;
      logic [31:0]        found_page;
      logic [15:0]        found_slot;
      logic [8:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [63:0] key;
      logic [31:0]        page;
      logic [15:0]        slot;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       srch_rd;
      logic       srch_cmp;
      logic       probe_rd;
      logic       ra_rd;
      logic       dn_init;
      logic       dn_rd;
      logic       dn_wr;
      logic       up_init;
      logic       up_rd;
      logic       up_wr;
      logic       put;
      logic       cnt_dec;
      logic       finish;
      logic [2:0] code;
      logic       take_loc;
      logic       take_all;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       full;
      logic       pos_ok;
      logic       srch_done;
      logic       lo_lt_cnt;
      logic       hit;
      logic       dn_more;
      logic       up_more;
   } stat_type;

endpackage

>>> rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted table of unique signed 64-bit keys with page/slot locators.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item and pulse start while busy is low; the item is taken at
//   that edge. func selects lookup, insert, remove or read-at.
//   One result per item appears on rsp_item with rsp_valid high for one
//   cycle; it must be taken then.
//   csr_wr_en/csr_wr_data write the capacity; the user must do this only
//   while the block is idle, as the block itself does not enforce it.
// Operation:
//   binary search over the single-read RAM: each halving step is a check,
//   a read and a compare, then a probe read at the found position.
//   Insert and remove shift one entry at a time (check, read, write).
//   Read-at, full and out-of-range results skip the search.
// Reset: entry count cleared, capacity back to 256; RAM contents are left
// as they are, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_key_table #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  skt_pkg::req_type req_item,
   output logic             rsp_valid,
   output skt_pkg::rsp_type rsp_item,
   input  logic             csr_wr_en,
   input  logic [8:0]       csr_wr_data
);

   skt_pkg::cmd_type  cmd;
   skt_pkg::stat_type stat;
   logic              start_ok;

   assign start_ok = start && !busy;

   skt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start_ok),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   skt_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule

>>> rtl/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
   parameter int WIDTH = 112,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/skt_dp.sv
// ----------------------------------------------------------------------------
// skt_dp
// Datapath: entry RAM, entry count, capacity register, search bounds,
// move index and the result register.
// ----------------------------------------------------------------------------
module skt_dp #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  skt_pkg::req_type  req_item,
   input  logic              csr_wr_en,
   input  logic [8:0]        csr_wr_data,
   input  skt_pkg::cmd_type  cmd,
   output skt_pkg::stat_type stat,
   output logic              rsp_valid,
   output skt_pkg::rsp_type  rsp_item
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = $bits(skt_pkg::entry_type);

   skt_pkg::req_type   req_ff;
   logic [8:0]         cap_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, idx_ff, idx_in;
   skt_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff;
   logic [CW:0]        mid_sum;
   logic [CW+8:0]      count_wide, cap_wide;
   logic [CW+7:0]      pos_wide, cnt_pos_wide;
   logic [CW+8:0]      count_out;
   logic [CW-1:0]      rd_idx;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   skt_pkg::entry_type wr_entry, rd_entry;
   logic [EW-1:0]      rd_raw;

   assign mid_sum      = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in       = mid_sum[CW:1];
   assign count_wide   = {9'd0, count_ff};
   assign cap_wide     = {{CW{1'b0}}, cap_ff};
   assign pos_wide     = {{CW{1'b0}}, req_ff.position};
   assign cnt_pos_wide = {8'd0, count_ff};
   assign count_out    = {9'd0, count_ff};
   assign rd_entry     = skt_pkg::entry_type'(rd_raw);

   // status back to the controller
   always_comb begin
      stat.func      = req_ff.func;
      stat.full      = (count_wide >= cap_wide) || (count_ff >= CW'(MAX_ENTRIES));
      stat.pos_ok    = (pos_wide < cnt_pos_wide);
      stat.srch_done = (lo_ff == hi_ff);
      stat.lo_lt_cnt = (lo_ff < count_ff);
      stat.hit       = (rd_entry.key == req_ff.search_key);
      stat.dn_more   = (idx_ff > lo_ff);
      stat.up_more   = ({1'b0, idx_ff} + {{CW{1'b0}}, 1'b1}) < {1'b0, count_ff};
   end

   // RAM addressing
   always_comb begin
      rd_idx = mid_in;
      if (cmd.probe_rd) begin
         rd_idx = lo_ff;
      end else if (cmd.dn_rd) begin
         rd_idx = idx_ff - CW'(1);
      end else if (cmd.up_rd) begin
         rd_idx = idx_ff + CW'(1);
      end else if (cmd.ra_rd) begin
         rd_idx = pos_wide[CW-1:0];
      end
      rd_addr = rd_idx[AW-1:0];

      wr_en    = cmd.dn_wr || cmd.up_wr || cmd.put;
      wr_addr  = cmd.put ? lo_ff[AW-1:0] : idx_ff[AW-1:0];
      wr_entry = rd_entry;
      if (cmd.put) begin
         wr_entry.key  = req_ff.search_key;
         wr_entry.page = req_ff.new_page;
         wr_entry.slot = req_ff.new_slot;
      end
   end

   skt_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      if (cmd.load) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.srch_cmp) begin
         if (rd_entry.key < req_ff.search_key) begin
            lo_in = mid_ff + CW'(1);
         end else begin
            hi_in = mid_ff;
         end
      end
      if (cmd.dn_init) idx_in = count_ff;
      if (cmd.dn_wr)   idx_in = idx_ff - CW'(1);
      if (cmd.up_init) idx_in = lo_ff;
      if (cmd.up_wr)   idx_in = idx_ff + CW'(1);
      if (cmd.put)     count_in = count_ff + CW'(1);
      if (cmd.cnt_dec) count_in = count_ff - CW'(1);

      rsp_in             = '0;
      rsp_in.status      = cmd.code;
      rsp_in.entry_count = count_out[8:0];
      if (cmd.take_loc || cmd.take_all) begin
         rsp_in.found_page = rd_entry.page;
         rsp_in.found_slot = rd_entry.slot;
      end
      if (cmd.take_all) begin
         rsp_in.found_key = rd_entry.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= skt_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.load)    req_ff <= req_item;
      if (cmd.srch_rd) mid_ff <= mid_in;
      if (cmd.finish)  rsp_ff <= rsp_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> rtl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Controller: binary search, probe, shift loops and result sequencing.
// ----------------------------------------------------------------------------
module skt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  skt_pkg::stat_type stat,
   output skt_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      IDLE, DISPATCH, S_CHK, S_RD, S_CMP, P_RD, P_CMP, RA_RD, RA_FIN,
      DN_CHK, DN_RD, DN_WR, PUT, UP_CHK, UP_RD, UP_WR
   } state_type;

   state_type state_ff, state_in;
   logic      fin_ok_ff, fin_ok_in;

   // key is absent: insert goes on to shift, others report a miss
   task automatic miss(output state_type nxt);
      nxt = IDLE;
      if (stat.func == skt_pkg::FUNC_INSERT) begin
         cmd.dn_init = 1'b1;
         nxt         = DN_CHK;
      end else begin
         cmd.finish = 1'b1;
         cmd.code   = skt_pkg::ST_MISS;
      end
   endtask

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      fin_ok_in = 1'b0;
      if (fin_ok_ff) begin
         cmd.finish = 1'b1;
         cmd.code   = skt_pkg::ST_OK;
      end
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            if (stat.func == skt_pkg::FUNC_READ) begin
               if (stat.pos_ok) begin
                  state_in = RA_RD;
               end else begin
                  cmd.finish = 1'b1;
                  cmd.code   = skt_pkg::ST_RANGE;
                  state_in   = IDLE;
               end
            end else if (stat.func == skt_pkg::FUNC_INSERT && stat.full) begin
               cmd.finish = 1'b1;
               cmd.code   = skt_pkg::ST_FULL;
               state_in   = IDLE;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (!stat.srch_done) begin
               state_in = S_RD;
            end else if (stat.lo_lt_cnt) begin
               state_in = P_RD;
            end else begin
               miss(state_in);
            end
         end
         S_RD: begin
            cmd.srch_rd = 1'b1;
            state_in    = S_CMP;
         end
         S_CMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = S_CHK;
         end
         P_RD: begin
            cmd.probe_rd = 1'b1;
            state_in     = P_CMP;
         end
         P_CMP: begin
            if (!stat.hit) begin
               miss(state_in);
            end else if (stat.func == skt_pkg::FUNC_LOOKUP) begin
               cmd.finish   = 1'b1;
               cmd.code     = skt_pkg::ST_OK;
               cmd.take_loc = 1'b1;
               state_in     = IDLE;
            end else if (stat.func == skt_pkg::FUNC_INSERT) begin
               cmd.finish = 1'b1;
               cmd.code   = skt_pkg::ST_DUP;
               state_in   = IDLE;
            end else begin
               cmd.up_init = 1'b1;
               state_in    = UP_CHK;
            end
         end
         RA_RD: begin
            cmd.ra_rd = 1'b1;
            state_in  = RA_FIN;
         end
         RA_FIN: begin
            cmd.finish   = 1'b1;
            cmd.code     = skt_pkg::ST_OK;
            cmd.take_all = 1'b1;
            state_in     = IDLE;
         end
         DN_CHK: state_in = stat.dn_more ? DN_RD : PUT;
         DN_RD: begin
            cmd.dn_rd = 1'b1;
            state_in  = DN_WR;
         end
         DN_WR: begin
            cmd.dn_wr = 1'b1;
            state_in  = DN_CHK;
         end
         PUT: begin
            cmd.put   = 1'b1;
            fin_ok_in = 1'b1;
            state_in  = IDLE;
         end
         UP_CHK: begin
            if (stat.up_more) begin
               state_in = UP_RD;
            end else begin
               cmd.cnt_dec = 1'b1;
               fin_ok_in   = 1'b1;
               state_in    = IDLE;
            end
         end
         UP_RD: begin
            cmd.up_rd = 1'b1;
            state_in  = UP_WR;
         end
         UP_WR: begin
            cmd.up_wr = 1'b1;
            state_in  = UP_CHK;
         end
         default: state_in = IDLE;
      endcase
   end

   // an ok result after a count update is finished in the cycle after the update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         fin_ok_ff <= 1'b0;
         busy      <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fin_ok_ff <= fin_ok_in;
         busy      <= (state_in != IDLE) || fin_ok_in;
      end
   end

endmodule

>>> rtl/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks on the sorted key table, bound to the top level.
// ----------------------------------------------------------------------------
module skt_checker #(
   parameter int MAX_ENTRIES = 256
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input skt_pkg::rsp_type rsp_item
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item taken but block not busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results back to back");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {23'd0, rsp_item.entry_count} <= MAX_ENTRIES)
      else $error("entry count above table size");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != skt_pkg::ST_OK |->
         rsp_item.found_key == 64'sd0 && rsp_item.found_page == 32'd0 &&
         rsp_item.found_slot == 16'd0)
      else $error("failed item returned data");

endmodule

bind sorted_key_table skt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_skt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
